>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned PayW        = 32;
  localparam int unsigned OccW        = 5;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdRemove = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StRemoved  = 2'd1,
    StEmpty    = 2'd2,
    StFull     = 2'd3
  } status_e;

  // Broadcast control to every cell of the row.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a key and payload and shifts them
// toward its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                                clk_i,
  input  spq_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                occ_i,
  input  logic signed [spq_pkg::KeyW-1:0]     new_key_i,
  input  logic signed [spq_pkg::PayW-1:0]     new_pay_i,
  input  logic                                prev_le_i,
  input  logic signed [spq_pkg::KeyW-1:0]     prev_key_i,
  input  logic signed [spq_pkg::PayW-1:0]     prev_pay_i,
  input  logic signed [spq_pkg::KeyW-1:0]     next_key_i,
  input  logic signed [spq_pkg::PayW-1:0]     next_pay_i,
  output logic                                le_o,
  output logic signed [spq_pkg::KeyW-1:0]     key_o,
  output logic signed [spq_pkg::PayW-1:0]     pay_o
);

  logic signed [spq_pkg::KeyW-1:0] key_q, key_d;
  logic signed [spq_pkg::PayW-1:0] pay_q, pay_d;

  // An occupied slot whose key is not above the new key keeps its place.
  assign le_o = occ_i && (key_q <= new_key_i);

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctrl_i.rem) begin
      key_d = next_key_i;
      pay_d = next_pay_i;
    end else if (ctrl_i.ins && !le_o) begin
      // The first slot past the keepers takes the new entry; the rest shift up.
      if (prev_le_i) begin
        key_d = new_key_i;
        pay_d = new_pay_i;
      end else begin
        key_d = prev_key_i;
        pay_d = prev_pay_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

>>> rtl/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded min-key priority queue built from a row of shifting cells.
// ----------------------------------------------------------------------------
// The queue takes one word per cycle, insert or remove, and returns one result
// word for each from an output register; it keeps taking words while that
// register holds a result only if the result is taken in the same cycle. Every
// cell compares its own key with the incoming key in parallel, so while results
// are taken the sustained rate is one word per cycle, set by that broadcast
// compare and the one-step shift between neighboring cells. Equal keys leave in
// arrival order. No clearing pass is needed after reset.
module sorted_priority_queue_top #(
  parameter int unsigned Capacity = spq_pkg::DefCapacity
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic signed [spq_pkg::KeyW-1:0]     key_i,
  input  logic signed [spq_pkg::PayW-1:0]     payload_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic signed [spq_pkg::KeyW-1:0]     out_key_o,
  output logic signed [spq_pkg::PayW-1:0]     out_payload_o,
  output logic [spq_pkg::OccW-1:0]            occupancy_o
);

  localparam int unsigned NeedW = $clog2(Capacity + 1);
  localparam int unsigned CntW  = (NeedW > spq_pkg::OccW) ? NeedW : spq_pkg::OccW;

  logic [CntW-1:0] count_q, count_d;
  logic            in_fire;
  logic            empty, full;
  spq_pkg::cell_ctrl_t ctrl;

  logic                        le     [Capacity];
  logic signed [spq_pkg::KeyW-1:0] cell_key [Capacity];
  logic signed [spq_pkg::PayW-1:0] cell_pay [Capacity];

  logic                            out_valid_q;
  spq_pkg::status_e                status_q, status_d;
  logic signed [spq_pkg::KeyW-1:0] out_key_q, out_key_d;
  logic signed [spq_pkg::PayW-1:0] out_pay_q, out_pay_d;
  logic [spq_pkg::OccW-1:0]        occ_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign empty      = (count_q == '0);
  assign full       = (count_q >= CntW'(Capacity));

  assign ctrl.ins = in_fire && (cmd_i == spq_pkg::CmdInsert) && !full;
  assign ctrl.rem = in_fire && (cmd_i == spq_pkg::CmdRemove) && !empty;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                            occ;
    logic                            prev_le;
    logic signed [spq_pkg::KeyW-1:0] prev_key, next_key;
    logic signed [spq_pkg::PayW-1:0] prev_pay, next_pay;

    assign occ = (count_q > CntW'(i));

    if (i == 0) begin : g_first
      assign prev_le  = 1'b1;
      assign prev_key = key_i;
      assign prev_pay = payload_i;
    end else begin : g_mid
      assign prev_le  = le[i-1];
      assign prev_key = cell_key[i-1];
      assign prev_pay = cell_pay[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign next_key = '0;
      assign next_pay = '0;
    end else begin : g_inner
      assign next_key = cell_key[i+1];
      assign next_pay = cell_pay[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ),
      .new_key_i  (key_i),
      .new_pay_i  (payload_i),
      .prev_le_i  (prev_le),
      .prev_key_i (prev_key),
      .prev_pay_i (prev_pay),
      .next_key_i (next_key),
      .next_pay_i (next_pay),
      .le_o       (le[i]),
      .key_o      (cell_key[i]),
      .pay_o      (cell_pay[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_key_d = '0;
    out_pay_d = '0;
    unique case (cmd_i)
      spq_pkg::CmdInsert: begin
        status_d = full ? spq_pkg::StFull : spq_pkg::StInserted;
      end
      spq_pkg::CmdRemove: begin
        if (empty) begin
          status_d = spq_pkg::StEmpty;
        end else begin
          status_d  = spq_pkg::StRemoved;
          out_key_d = cell_key[0];
          out_pay_d = cell_pay[0];
        end
      end
      default: status_d = spq_pkg::StEmpty;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q  <= status_d;
      out_key_q <= out_key_d;
      out_pay_q <= out_pay_d;
      occ_q     <= count_d[spq_pkg::OccW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_key_o     = out_key_q;
  assign out_payload_o = out_pay_q;
  assign occupancy_o   = occ_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the count");

  a_remove_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rem |=> out_valid_q && status_q == spq_pkg::StRemoved)
    else $error("remove did not report a removed word");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !in_fire)
    else $error("result register overwritten while stalled");
`endif

endmodule
